@@ hw/rtl/rta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_pkg
// Shared constants, widths and types of the rgb tone adjust pipeline.
// ----------------------------------------------------------------------------
package rta_pkg;

    // fractional bits of the unsigned gains
    localparam int GAIN_FRAC_BITS = 12;

    localparam int PIX_W    = 8;
    localparam int GAIN_W   = 16;
    localparam int BRIGHT_W = 9;
    localparam int WARM_W   = 8;

    // apb port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_EXPOSURE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CONTRAST   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SATURATION = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WARMTH     = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC_BITS);

    // pipeline depth
    localparam int LANE_STAGES = 3;
    localparam int MIX_STAGES  = 5;
    localparam int NUM_STAGES  = LANE_STAGES + MIX_STAGES;

    // exposure / brightness stage
    localparam int PROD_A_W = PIX_W + GAIN_W;
    localparam int S_W = (((PROD_A_W + 1) > (BRIGHT_W + GAIN_FRAC_BITS)) ?
                          (PROD_A_W + 1) : (BRIGHT_W + GAIN_FRAC_BITS)) + 1;
    localparam int A_W = S_W - GAIN_FRAC_BITS + 1;

    // contrast stage, mid-grey in half units
    localparam int MID_GREY  = 255;
    localparam int D_W       = A_W + 1;
    localparam int P_W       = D_W + GAIN_W + 1;
    localparam int CON_LIMIT = 524288;
    localparam int C_W       = 21;

    // luma and saturation stages
    localparam int LUMA_FRAC = 16;
    localparam int LUMA_W    = 17;
    localparam logic signed [LUMA_W-1:0] LUMA_WEIGHT [3] = '{
        LUMA_W'(13933), LUMA_W'(46871), LUMA_W'(4732)
    };
    localparam int LP_W      = C_W + LUMA_FRAC;
    localparam int L_W       = LP_W + 1;
    localparam int X_W       = L_W + 1;
    localparam int M_W       = X_W + GAIN_W + 1;
    localparam int T_W       = M_W + 2;
    localparam int OUT_SHIFT = LUMA_FRAC + 1 + GAIN_FRAC_BITS;
    localparam int Q_W       = T_W - OUT_SHIFT;
    localparam int PIX_MAX   = 255;

    typedef struct packed {
        logic        [GAIN_W-1:0]   exposure_gain;
        logic signed [BRIGHT_W-1:0] brightness_offset;
        logic        [GAIN_W-1:0]   contrast_gain;
        logic        [GAIN_W-1:0]   saturation_gain;
        logic signed [WARM_W-1:0]   warmth_offset;
    } rta_cfg_t;

endpackage

@@ hw/rtl/rta_pix_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_pix_in_if
// Valid/ready stream of input rgba pixels.
// ----------------------------------------------------------------------------
interface rta_pix_in_if
    import rta_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic [PIX_W-1:0] alpha_in;
    logic             frame_end_in;

    modport source (
        output valid, red_in, green_in, blue_in, alpha_in, frame_end_in,
        input  ready
    );

    modport sink (
        input  valid, red_in, green_in, blue_in, alpha_in, frame_end_in,
        output ready
    );
endinterface

@@ hw/rtl/rta_pix_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_pix_out_if
// Valid/ready stream of adjusted rgba pixels.
// ----------------------------------------------------------------------------
interface rta_pix_out_if
    import rta_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic [PIX_W-1:0] alpha_out;
    logic             frame_end_out;

    modport source (
        output valid, red_out, green_out, blue_out, alpha_out, frame_end_out,
        input  ready
    );

    modport sink (
        input  valid, red_out, green_out, blue_out, alpha_out, frame_end_out,
        output ready
    );
endinterface

@@ hw/rtl/rta_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_cfg_regs
// APB register file holding the five tone adjustment settings.
// ----------------------------------------------------------------------------
module rta_cfg_regs
    import rta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output rta_cfg_t          cfg
);

    rta_cfg_t               cfg_reg;
    rta_cfg_t               cfg_next;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_EXPOSURE:   cfg_next.exposure_gain     = pwdata[GAIN_W-1:0];
                REG_BRIGHTNESS: cfg_next.brightness_offset = $signed(pwdata[BRIGHT_W-1:0]);
                REG_CONTRAST:   cfg_next.contrast_gain     = pwdata[GAIN_W-1:0];
                REG_SATURATION: cfg_next.saturation_gain   = pwdata[GAIN_W-1:0];
                REG_WARMTH:     cfg_next.warmth_offset     = $signed(pwdata[WARM_W-1:0]);
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.exposure_gain     <= GAIN_ONE;
            cfg_reg.brightness_offset <= '0;
            cfg_reg.contrast_gain     <= GAIN_ONE;
            cfg_reg.saturation_gain   <= GAIN_ONE;
            cfg_reg.warmth_offset     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // signed registers read back sign-extended
    always_comb
    begin
        case (reg_idx)
            REG_EXPOSURE:   prdata = DATA_W'(cfg_reg.exposure_gain);
            REG_BRIGHTNESS: prdata = DATA_W'(cfg_reg.brightness_offset);
            REG_CONTRAST:   prdata = DATA_W'(cfg_reg.contrast_gain);
            REG_SATURATION: prdata = DATA_W'(cfg_reg.saturation_gain);
            REG_WARMTH:     prdata = DATA_W'(cfg_reg.warmth_offset);
            default:        prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/rta_pipe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_pipe_ctrl
// Per-stage valid bits and load enables of the elastic pipeline.
// ----------------------------------------------------------------------------
module rta_pipe_ctrl
    import rta_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [NUM_STAGES-1:0] load
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   ready;
    logic [NUM_STAGES-1:0] upstream;

    assign upstream = {valid_reg[NUM_STAGES-2:0], in_valid};

    // a stage can take data when empty or when it drains this cycle
    always_comb
    begin
        ready[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign valid_next = (ready[NUM_STAGES-1:0] & upstream)
                      | (~ready[NUM_STAGES-1:0] & valid_reg);
    assign load       = ready[NUM_STAGES-1:0] & upstream;
    assign in_ready   = ready[0];
    assign out_valid  = valid_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

@@ hw/rtl/rta_contrast_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_contrast_lane
// One color channel: exposure gain and brightness, then contrast around
// mid-grey, result in half pixel units.
// ----------------------------------------------------------------------------
module rta_contrast_lane
    import rta_pkg::*;
(
    input  logic                   clk,
    input  rta_cfg_t               cfg,
    input  logic [LANE_STAGES-1:0] load,
    input  logic [PIX_W-1:0]       pix,
    output logic signed [C_W-1:0]  con
);

    logic        [PROD_A_W-1:0] prod;
    logic signed [S_W-1:0]      sum_a;
    logic signed [A_W-1:0]      a_next;
    logic signed [A_W-1:0]      a_reg;
    logic signed [D_W-1:0]      dev;
    logic signed [P_W-1:0]      p_next;
    logic signed [P_W-1:0]      p_reg;
    logic signed [P_W:0]        q_wide;
    logic signed [C_W-1:0]      c_next;
    logic signed [C_W-1:0]      c_reg;

    always_comb
    begin
        prod   = PROD_A_W'(pix) * PROD_A_W'(cfg.exposure_gain);
        sum_a  = $signed(S_W'(prod))
               + (S_W'(cfg.brightness_offset) <<< GAIN_FRAC_BITS);
        a_next = A_W'(sum_a >>> (GAIN_FRAC_BITS - 1));
    end

    always_comb
    begin
        dev    = D_W'(a_reg) - D_W'(MID_GREY);
        p_next = P_W'(dev) * P_W'($signed({1'b0, cfg.contrast_gain}));
    end

    // floor shift back to half units, then saturate
    always_comb
    begin
        q_wide = ((P_W+1)'(p_reg) >>> GAIN_FRAC_BITS) + (P_W+1)'(MID_GREY);
        if (q_wide > (P_W+1)'(CON_LIMIT))
        begin
            c_next = C_W'(CON_LIMIT);
        end
        else if (q_wide < -((P_W+1)'(CON_LIMIT)))
        begin
            c_next = -(C_W'(CON_LIMIT));
        end
        else
        begin
            c_next = C_W'(q_wide);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            a_reg <= a_next;
        end
        if (load[1])
        begin
            p_reg <= p_next;
        end
        if (load[2])
        begin
            c_reg <= c_next;
        end
    end

    assign con = c_reg;

endmodule

@@ hw/rtl/rta_luma_mix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_luma_mix
// Rec.709 luma, saturation blend away from luma, warmth offset and the
// final floor and clamp of all three channels.
// ----------------------------------------------------------------------------
module rta_luma_mix
    import rta_pkg::*;
(
    input  logic                  clk,
    input  rta_cfg_t              cfg,
    input  logic [MIX_STAGES-1:0] load,
    input  logic signed [C_W-1:0] con_r,
    input  logic signed [C_W-1:0] con_g,
    input  logic signed [C_W-1:0] con_b,
    output logic [PIX_W-1:0]      red,
    output logic [PIX_W-1:0]      green,
    output logic [PIX_W-1:0]      blue
);

    logic signed [C_W-1:0]  con_in [3];
    logic signed [C_W-1:0]  c4_reg [3];
    logic signed [LP_W-1:0] lp_reg [3];
    logic signed [C_W-1:0]  c5_reg [3];
    logic signed [L_W-1:0]  l5_reg;
    logic signed [L_W-1:0]  l6_reg;
    logic signed [X_W-1:0]  x_reg  [3];
    logic signed [L_W-1:0]  l7_reg;
    logic signed [M_W-1:0]  m_reg  [3];
    logic        [PIX_W-1:0] out_reg [3];
    logic signed [L_W-1:0]  l_next;
    logic signed [T_W-1:0]  warm_t;
    logic signed [T_W-1:0]  base_t;
    logic signed [T_W-1:0]  t_val  [3];
    logic        [PIX_W-1:0] out_next [3];

    function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [Q_W-1:0] q);
        logic [PIX_W-1:0] r;
        if (q < 0)
        begin
            r = '0;
        end
        else if (q > Q_W'(PIX_MAX))
        begin
            r = '1;
        end
        else
        begin
            r = q[PIX_W-1:0];
        end
        return r;
    endfunction

    assign con_in[0] = con_r;
    assign con_in[1] = con_g;
    assign con_in[2] = con_b;

    assign l_next = L_W'(lp_reg[0]) + L_W'(lp_reg[1]) + L_W'(lp_reg[2]);

    // final sum: luma base plus blended deviation, warmth on red and blue
    always_comb
    begin
        warm_t = T_W'(cfg.warmth_offset) <<< OUT_SHIFT;
        base_t = T_W'(l7_reg) <<< GAIN_FRAC_BITS;
        t_val[0] = base_t + T_W'(m_reg[0]) + warm_t;
        t_val[1] = base_t + T_W'(m_reg[1]);
        t_val[2] = base_t + T_W'(m_reg[2]) - warm_t;
        for (int i = 0; i < 3; i++)
        begin
            out_next[i] = clamp_pix(Q_W'(t_val[i] >>> OUT_SHIFT));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (load[0])
            begin
                c4_reg[i] <= con_in[i];
                lp_reg[i] <= LP_W'(con_in[i]) * LP_W'(LUMA_WEIGHT[i]);
            end
            if (load[1])
            begin
                c5_reg[i] <= c4_reg[i];
            end
            if (load[2])
            begin
                x_reg[i] <= (X_W'(c5_reg[i]) <<< LUMA_FRAC) - X_W'(l5_reg);
            end
            if (load[3])
            begin
                m_reg[i] <= M_W'(x_reg[i])
                          * M_W'($signed({1'b0, cfg.saturation_gain}));
            end
            if (load[4])
            begin
                out_reg[i] <= out_next[i];
            end
        end
        if (load[1])
        begin
            l5_reg <= l_next;
        end
        if (load[2])
        begin
            l6_reg <= l5_reg;
        end
        if (load[3])
        begin
            l7_reg <= l6_reg;
        end
    end

    assign red   = out_reg[0];
    assign green = out_reg[1];
    assign blue  = out_reg[2];

endmodule

@@ hw/rtl/rgb_tone_adjust.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_tone_adjust
// Exposure, brightness, contrast, saturation and warmth adjustment of an
// rgba pixel stream.
// ----------------------------------------------------------------------------
// usage:
//   pix_in takes one rgba pixel per transfer, pix_out gives one adjusted
//   pixel per transfer, in order. alpha and frame end pass through.
//   settings sit behind an apb port (exposure 0x00, brightness 0x04,
//   contrast 0x08, saturation 0x0c, warmth 0x10); write them while the
//   stream is idle. pready is always high.
//   a pixel passes through three stages per channel for gain and
//   contrast, then five for luma, blend and clamp, each stage holding
//   at most one multiplier. throughput is one pixel per cycle while
//   pix_out is not stalled; each stage has its own valid bit,
//   so bubbles close up and input keeps being taken while a result waits.
//   when the receiver stalls, the pipeline fills and pix_in.ready drops
//   only once all 8 stages hold a pixel; nothing is dropped or repeated.
//   reset clears all valid bits and loads neutral settings (gains 1.0,
//   offsets 0), under which output equals input.
// ----------------------------------------------------------------------------
module rgb_tone_adjust
    import rta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    rta_pix_in_if.sink        pix_in,
    rta_pix_out_if.source     pix_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef struct packed {
        logic [PIX_W-1:0] alpha;
        logic             frame_end;
    } rta_side_t;

    rta_cfg_t              cfg;
    logic [NUM_STAGES-1:0] load;
    logic signed [C_W-1:0] con_r;
    logic signed [C_W-1:0] con_g;
    logic signed [C_W-1:0] con_b;
    rta_side_t             side_reg [NUM_STAGES];

    rta_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rta_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .load      (load)
    );

    rta_contrast_lane u_lane_r (
        .clk  (clk),
        .cfg  (cfg),
        .load (load[LANE_STAGES-1:0]),
        .pix  (pix_in.red_in),
        .con  (con_r)
    );

    rta_contrast_lane u_lane_g (
        .clk  (clk),
        .cfg  (cfg),
        .load (load[LANE_STAGES-1:0]),
        .pix  (pix_in.green_in),
        .con  (con_g)
    );

    rta_contrast_lane u_lane_b (
        .clk  (clk),
        .cfg  (cfg),
        .load (load[LANE_STAGES-1:0]),
        .pix  (pix_in.blue_in),
        .con  (con_b)
    );

    rta_luma_mix u_mix (
        .clk   (clk),
        .cfg   (cfg),
        .load  (load[NUM_STAGES-1:LANE_STAGES]),
        .con_r (con_r),
        .con_g (con_g),
        .con_b (con_b),
        .red   (pix_out.red_out),
        .green (pix_out.green_out),
        .blue  (pix_out.blue_out)
    );

    // alpha and frame end ride along with the color stages
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            side_reg[0] <= '{alpha: pix_in.alpha_in, frame_end: pix_in.frame_end_in};
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (load[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign pix_out.alpha_out     = side_reg[NUM_STAGES-1].alpha;
    assign pix_out.frame_end_out = side_reg[NUM_STAGES-1].frame_end;

    // input is only refused when every stage is full and the output stalls
    a_ready_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !pix_in.ready |-> (pix_out.valid && !pix_out.ready)
    ) else $error("input refused while pipeline has room");

    a_warmth_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_WARMTH))
        |=> (cfg.warmth_offset == $past(pwdata[WARM_W-1:0]))
    ) else $error("warmth register write lost");

    a_exposure_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_EXPOSURE))
        |=> (cfg.exposure_gain == $past(pwdata[GAIN_W-1:0]))
    ) else $error("exposure register write lost");

endmodule
